FILE: src/align_frame_features_core_macros.svh
// Assertion macros used by the aff_back module of the align_frame_features_core RTL.
// Depends on nothing; each user supplies clk and rst_n in scope.
`ifndef ALIGN_FRAME_FEATURES_CORE_MACROS_SVH
`define ALIGN_FRAME_FEATURES_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AFF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define AFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/aff_pkg.sv
// Shared types and constants for the feature alignment core.
// Depends on nothing; used by every module of the core.
package aff_pkg;

    localparam int MAX_FEAT = 16;
    localparam int IDX_W    = (MAX_FEAT > 1) ? $clog2(MAX_FEAT) : 1;
    localparam int CNT_W    = $clog2(MAX_FEAT + 1);
    localparam int LIM_W    = 34;
    localparam int SQ_W     = 32;
    localparam int DIST_W   = 33;
    localparam int CRD_W    = 16;
    localparam int ANG_W    = 14;
    localparam int CFG_IDX_W = 2;

    // Request codes
    localparam logic [1:0] REQ_OLD = 2'd0;
    localparam logic [1:0] REQ_NEW = 2'd1;
    localparam logic [1:0] REQ_RUN = 2'd2;

    // Slot kinds
    localparam logic [1:0] KIND_MATCH  = 2'd0;
    localparam logic [1:0] KIND_HOLD   = 2'd1;
    localparam logic [1:0] KIND_FILL   = 2'd2;
    localparam logic [1:0] KIND_APPEND = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH  = 2'd1;

    localparam logic [LIM_W-1:0] SEARCH_RESET = 34'd256000;
    localparam logic [LIM_W-1:0] MATCH_RESET  = 34'd5120;

    localparam logic signed [ANG_W-1:0] ANGLE_UNDEF = -14'sd16;

    typedef struct packed {
        logic [CRD_W-1:0]        x;
        logic [CRD_W-1:0]        y;
        logic [CRD_W-1:0]        size;
        logic signed [ANG_W-1:0] angle;
    } feat_t;

    typedef struct packed {
        logic [1:0] req;
        feat_t      feat;
    } req_item_t;

    typedef struct packed {
        logic      valid;
        req_item_t item;
    } req_head_t;

    typedef struct packed {
        feat_t      feat;
        logic [1:0] kind;
    } slot_t;

endpackage

FILE: src/aff_front.sv
// Front end: takes command words, drops unused codes, queues the rest.
// Depends on aff_pkg.
module aff_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 req_type,
    input  logic [aff_pkg::CRD_W-1:0]  pos_x,
    input  logic [aff_pkg::CRD_W-1:0]  pos_y,
    input  logic [aff_pkg::CRD_W-1:0]  feat_size,
    input  logic signed [aff_pkg::ANG_W-1:0] feat_angle,
    input  logic                       pop,
    output aff_pkg::req_head_t         head
);

    aff_pkg::req_item_t q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       accept;
    logic       push;
    logic       do_pop;

    // Accept a word when there is room; keep only known requests
    assign busy   = (cnt_reg == 2'd2);
    assign accept = start && !busy;
    assign push   = accept && (req_type == aff_pkg::REQ_OLD || req_type == aff_pkg::REQ_NEW
                               || req_type == aff_pkg::REQ_RUN);
    assign do_pop = pop && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].req        <= req_type;
            q_reg[wr_ptr_reg].feat.x     <= pos_x;
            q_reg[wr_ptr_reg].feat.y     <= pos_y;
            q_reg[wr_ptr_reg].feat.size  <= feat_size;
            q_reg[wr_ptr_reg].feat.angle <= feat_angle;
        end
    end

endmodule

FILE: src/aff_back.sv
// Back end: feature stores, greedy nearest-neighbor search, fill and output.
// Depends on aff_pkg and align_frame_features_core_macros.svh.
`include "align_frame_features_core_macros.svh"

module aff_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  aff_pkg::req_head_t                head,
    output logic                              pop,
    input  logic [aff_pkg::LIM_W-1:0]         search_limit,
    input  logic [aff_pkg::LIM_W-1:0]         match_limit,
    output logic                              result_valid,
    output logic [aff_pkg::CRD_W-1:0]         out_x,
    output logic [aff_pkg::CRD_W-1:0]         out_y,
    output logic [aff_pkg::CRD_W-1:0]         out_size,
    output logic signed [aff_pkg::ANG_W-1:0]  out_angle,
    output logic [1:0]                        slot_kind,
    output logic                              last
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEARCH   = 3'd1;
    localparam logic [2:0] ST_DECIDE   = 3'd2;
    localparam logic [2:0] ST_FILL     = 3'd3;
    localparam logic [2:0] ST_EMIT_OLD = 3'd4;
    localparam logic [2:0] ST_EMIT_NEW = 3'd5;

    localparam int MF = aff_pkg::MAX_FEAT;
    localparam int IW = aff_pkg::IDX_W;
    localparam int CW = aff_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(MF);

    logic [2:0]    state_reg;
    logic [CW-1:0] old_cnt_reg;
    logic [CW-1:0] new_cnt_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [MF-1:0] taken_reg;
    logic [aff_pkg::LIM_W-1:0] best_reg;
    logic [IW-1:0] bi_reg;
    logic          found_reg;
    logic          p_valid_reg;
    logic [IW-1:0] p_j_reg;
    logic [aff_pkg::CRD_W-1:0] p_dx_reg;
    logic [aff_pkg::CRD_W-1:0] p_dy_reg;

    aff_pkg::feat_t old_mem [MF];
    aff_pkg::feat_t new_mem [MF];
    aff_pkg::slot_t out_mem [MF];

    logic [IW-1:0] i_idx;
    logic [IW-1:0] j_idx;
    aff_pkg::feat_t old_i;
    aff_pkg::feat_t new_j;
    aff_pkg::feat_t new_bi;
    aff_pkg::slot_t out_i;
    aff_pkg::feat_t hold_feat;
    aff_pkg::feat_t old_load_feat;
    logic [aff_pkg::CRD_W-1:0] dx;
    logic [aff_pkg::CRD_W-1:0] dy;
    logic [aff_pkg::DIST_W-1:0] sq_sum;
    logic          better;
    logic          keep;
    logic [MF-1:0] untaken;
    logic          more_new_all;
    logic          more_after_j;
    logic [CW-1:0] j_plus;
    logic          load_old;
    logic          load_new;
    logic          start_run;
    logic          fill_slot;
    logic          fill_take;
    logic          emit_old;
    logic          emit_new;
    logic          emit_last;

    // Read ports
    assign i_idx  = i_reg[IW-1:0];
    assign j_idx  = j_reg[IW-1:0];
    assign old_i  = old_mem[i_idx];
    assign new_j  = new_mem[j_idx];
    assign new_bi = new_mem[bi_reg];
    assign out_i  = out_mem[i_idx];

    always_comb
    begin
        hold_feat       = old_i;
        hold_feat.size  = '0;
        hold_feat.angle = aff_pkg::ANGLE_UNDEF;
    end

    // Old features keep no angle
    always_comb
    begin
        old_load_feat       = head.item.feat;
        old_load_feat.angle = aff_pkg::ANGLE_UNDEF;
    end

    // Distance stage one: absolute differences
    assign dx = (old_i.x > new_j.x) ? old_i.x - new_j.x : new_j.x - old_i.x;
    assign dy = (old_i.y > new_j.y) ? old_i.y - new_j.y : new_j.y - old_i.y;

    // Distance stage two: squares, sum and compare with the running best
    assign sq_sum = {1'b0, aff_pkg::SQ_W'(p_dx_reg * p_dx_reg)}
                  + {1'b0, aff_pkg::SQ_W'(p_dy_reg * p_dy_reg)};
    assign better = p_valid_reg && ({1'b0, sq_sum} < best_reg);
    assign keep   = found_reg && ((best_reg < match_limit) || (old_i.size == '0));

    // Leftover new features
    always_comb
    begin
        for (int k = 0; k < MF; k++)
            untaken[k] = !taken_reg[k] && (CW'(k) < new_cnt_reg);
    end
    assign j_plus       = j_reg + CW'(1);
    assign more_new_all = |untaken;
    assign more_after_j = |(untaken >> j_plus);

    // Decode actions
    assign pop       = head.valid && (state_reg == ST_IDLE);
    assign load_old  = pop && head.item.req == aff_pkg::REQ_OLD && old_cnt_reg < CNT_MAX;
    assign load_new  = pop && head.item.req == aff_pkg::REQ_NEW && new_cnt_reg < CNT_MAX;
    assign start_run = pop && head.item.req == aff_pkg::REQ_RUN;
    assign fill_slot = (state_reg == ST_FILL) && (i_reg != old_cnt_reg)
                       && (old_i.size == '0) && (out_i.feat.size == '0);
    assign fill_take = fill_slot && (j_reg < new_cnt_reg) && !taken_reg[j_idx];
    assign emit_old  = (state_reg == ST_EMIT_OLD) && (i_reg != old_cnt_reg);
    assign emit_new  = (state_reg == ST_EMIT_NEW) && (j_reg != new_cnt_reg)
                       && !taken_reg[j_idx];
    assign emit_last = emit_old ? ((i_reg + CW'(1) == old_cnt_reg) && !more_new_all)
                                : !more_after_j;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            old_cnt_reg  <= '0;
            new_cnt_reg  <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            taken_reg    <= '0;
            best_reg     <= '0;
            bi_reg       <= '0;
            found_reg    <= 1'b0;
            p_valid_reg  <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= emit_old || emit_new;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_old)
                        old_cnt_reg <= old_cnt_reg + CW'(1);
                    if (load_new)
                        new_cnt_reg <= new_cnt_reg + CW'(1);
                    if (start_run)
                    begin
                        i_reg       <= '0;
                        j_reg       <= '0;
                        best_reg    <= search_limit;
                        found_reg   <= 1'b0;
                        p_valid_reg <= 1'b0;
                        state_reg   <= (old_cnt_reg == '0) ? ST_FILL : ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (better)
                    begin
                        best_reg  <= {1'b0, sq_sum};
                        bi_reg    <= p_j_reg;
                        found_reg <= 1'b1;
                    end
                    if (j_reg < new_cnt_reg)
                    begin
                        p_valid_reg <= !taken_reg[j_idx];
                        p_j_reg     <= j_idx;
                        j_reg       <= j_plus;
                    end
                    else
                    begin
                        p_valid_reg <= 1'b0;
                        if (!p_valid_reg)
                            state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (keep)
                        taken_reg[bi_reg] <= 1'b1;
                    j_reg     <= '0;
                    best_reg  <= search_limit;
                    found_reg <= 1'b0;
                    if (i_reg + CW'(1) == old_cnt_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_FILL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_FILL:
                begin
                    if (i_reg == old_cnt_reg || (fill_slot && j_reg >= new_cnt_reg))
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_EMIT_OLD;
                    end
                    else if (fill_slot)
                    begin
                        j_reg <= j_plus;
                        if (fill_take)
                        begin
                            taken_reg[j_idx] <= 1'b1;
                            i_reg            <= i_reg + CW'(1);
                        end
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end
                ST_EMIT_OLD:
                begin
                    if (i_reg == old_cnt_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_EMIT_NEW;
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end
                ST_EMIT_NEW:
                begin
                    if (j_reg == new_cnt_reg)
                    begin
                        old_cnt_reg <= '0;
                        new_cnt_reg <= '0;
                        taken_reg   <= '0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                        j_reg <= j_plus;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Stores, distance stage and result words
    always_ff @(posedge clk)
    begin
        if (load_old)
            old_mem[old_cnt_reg[IW-1:0]] <= old_load_feat;
        if (load_new)
            new_mem[new_cnt_reg[IW-1:0]] <= head.item.feat;
        if (state_reg == ST_DECIDE)
        begin
            if (keep)
                out_mem[i_idx] <= '{feat: new_bi, kind: aff_pkg::KIND_MATCH};
            else
                out_mem[i_idx] <= '{feat: hold_feat, kind: aff_pkg::KIND_HOLD};
        end
        if (fill_take)
            out_mem[i_idx] <= '{feat: new_j, kind: aff_pkg::KIND_FILL};
        p_dx_reg <= dx;
        p_dy_reg <= dy;
        if (emit_old)
        begin
            out_x     <= out_i.feat.x;
            out_y     <= out_i.feat.y;
            out_size  <= out_i.feat.size;
            out_angle <= out_i.feat.angle;
            slot_kind <= out_i.kind;
            last      <= emit_last;
        end
        else if (emit_new)
        begin
            out_x     <= new_j.x;
            out_y     <= new_j.y;
            out_size  <= new_j.size;
            out_angle <= new_j.angle;
            slot_kind <= aff_pkg::KIND_APPEND;
            last      <= emit_last;
        end
    end

    `AFF_ASSERT_NEXT(a_strobe_from_emit, !(emit_old || emit_new), !result_valid, "result without emit")
    `AFF_ASSERT_SAME(a_idle_clear, state_reg == ST_IDLE, taken_reg == '0, "taken flags left set")
    `AFF_ASSERT_SAME(a_cnt_bound, 1'b1, old_cnt_reg <= CNT_MAX && new_cnt_reg <= CNT_MAX, "count overflow")

endmodule

FILE: src/align_frame_features_core.sv
// Feature alignment core: configuration registers, front queue and back end.
// Depends on aff_pkg, aff_front and aff_back.
// A load is written into the two-word queue and then into its feature store; the queue
// takes a word a cycle while not busy, and raises busy when both slots are full, as they
// fill while a run holds the back end. The search makes one distance check per cycle;
// results leave unstalled, skipping new features already taken. Reset empties the lists.
module align_frame_features_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic [aff_pkg::CRD_W-1:0]         pos_x,
    input  logic [aff_pkg::CRD_W-1:0]         pos_y,
    input  logic [aff_pkg::CRD_W-1:0]         feat_size,
    input  logic signed [aff_pkg::ANG_W-1:0]  feat_angle,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [aff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aff_pkg::LIM_W-1:0]         cfg_data,
    output logic                              result_valid,
    output logic [aff_pkg::CRD_W-1:0]         out_x,
    output logic [aff_pkg::CRD_W-1:0]         out_y,
    output logic [aff_pkg::CRD_W-1:0]         out_size,
    output logic signed [aff_pkg::ANG_W-1:0]  out_angle,
    output logic [1:0]                        slot_kind,
    output logic                              last
);

    logic [aff_pkg::LIM_W-1:0] search_limit_reg;
    logic [aff_pkg::LIM_W-1:0] match_limit_reg;
    aff_pkg::req_head_t head;
    logic pop;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_limit_reg <= aff_pkg::SEARCH_RESET;
            match_limit_reg  <= aff_pkg::MATCH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == aff_pkg::CFG_SEARCH)
                search_limit_reg <= cfg_data;
            else if (cfg_index == aff_pkg::CFG_MATCH)
                match_limit_reg <= cfg_data;
        end
    end

    aff_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .feat_size  (feat_size),
        .feat_angle (feat_angle),
        .pop        (pop),
        .head       (head)
    );

    aff_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .search_limit (search_limit_reg),
        .match_limit  (match_limit_reg),
        .result_valid (result_valid),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_size     (out_size),
        .out_angle    (out_angle),
        .slot_kind    (slot_kind),
        .last         (last)
    );

endmodule

FILE: sim/align_frame_features_core_test.sv
// Self-checking testbench for align_frame_features_core: random frames of
// old/new feature lists, with the aligned slots predicted inside the bench.
// Depends on aff_pkg and the align_frame_features_core RTL.
module align_frame_features_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Request code that the block ignores
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        logic [1:0]     req;
        aff_pkg::feat_t feat;
    } word_t;

    typedef struct {
        aff_pkg::feat_t feat;
        logic [1:0]     kind;
        logic           fin;
    } slot_exp_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [1:0]                       req_type;
    logic [aff_pkg::CRD_W-1:0]        pos_x;
    logic [aff_pkg::CRD_W-1:0]        pos_y;
    logic [aff_pkg::CRD_W-1:0]        feat_size;
    logic signed [aff_pkg::ANG_W-1:0] feat_angle;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [aff_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [aff_pkg::LIM_W-1:0]        cfg_data;
    logic                             result_valid;
    logic [aff_pkg::CRD_W-1:0]        out_x;
    logic [aff_pkg::CRD_W-1:0]        out_y;
    logic [aff_pkg::CRD_W-1:0]        out_size;
    logic signed [aff_pkg::ANG_W-1:0] out_angle;
    logic [1:0]                       slot_kind;
    logic                             last;

    word_t     pending_words[$];
    slot_exp_t aligned_slots[$];

    // Predictor state
    aff_pkg::feat_t            prev_list[aff_pkg::MAX_FEAT];
    aff_pkg::feat_t            next_list[aff_pkg::MAX_FEAT];
    int                        prev_cnt;
    int                        next_cnt;
    logic [aff_pkg::LIM_W-1:0] search_lim;
    logic [aff_pkg::LIM_W-1:0] match_lim;

    logic word_taken;
    logic cfg_taken;
    logic steady;
    int   errors;
    int   cycles;

    align_frame_features_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Squared distance between two feature positions
    function automatic logic [aff_pkg::LIM_W:0] dist_sq(aff_pkg::feat_t a, aff_pkg::feat_t b);
        logic [aff_pkg::CRD_W-1:0] dx;
        logic [aff_pkg::CRD_W-1:0] dy;
        dx = (a.x > b.x) ? a.x - b.x : b.x - a.x;
        dy = (a.y > b.y) ? a.y - b.y : b.y - a.y;
        return (aff_pkg::LIM_W + 1)'(dx) * dx + (aff_pkg::LIM_W + 1)'(dy) * dy;
    endfunction

    // Greedy alignment of the loaded lists, queueing each aligned slot
    task automatic align_lists();
        bit                      used[aff_pkg::MAX_FEAT];
        aff_pkg::slot_t          res[aff_pkg::MAX_FEAT];
        slot_exp_t               e;
        logic [aff_pkg::LIM_W:0] best;
        logic [aff_pkg::LIM_W:0] d;
        bit                      found;
        int                      bi;
        int                      j;
        int                      n;
        n = 0;
        foreach (used[k]) used[k] = 0;
        for (int i = 0; i < prev_cnt; i++)
        begin
            best = (aff_pkg::LIM_W + 1)'(search_lim);
            found = 0;
            bi = 0;
            for (int k = 0; k < next_cnt; k++)
            begin
                if (used[k]) continue;
                d = dist_sq(next_list[k], prev_list[i]);
                if (d < best)
                begin
                    best = d;
                    bi = k;
                    found = 1;
                end
            end
            if (found && (best < match_lim || prev_list[i].size == 0))
            begin
                used[bi] = 1;
                res[i].feat = next_list[bi];
                res[i].kind = aff_pkg::KIND_MATCH;
            end
            else
            begin
                res[i].feat = prev_list[i];
                res[i].feat.size = '0;
                res[i].feat.angle = aff_pkg::ANGLE_UNDEF;
                res[i].kind = aff_pkg::KIND_HOLD;
            end
        end
        // Fill slots that were and stayed empty
        j = 0;
        for (int i = 0; i < prev_cnt; i++)
        begin
            if (prev_list[i].size == 0 && res[i].feat.size == 0)
            begin
                while (j < next_cnt && used[j]) j++;
                if (j >= next_cnt) break;
                used[j] = 1;
                res[i].feat = next_list[j];
                res[i].kind = aff_pkg::KIND_FILL;
            end
        end
        for (int i = 0; i < prev_cnt; i++)
        begin
            e.feat = res[i].feat;
            e.kind = res[i].kind;
            e.fin = 0;
            aligned_slots = {aligned_slots, e};
            n++;
        end
        for (int k = 0; k < next_cnt; k++)
        begin
            if (!used[k])
            begin
                e.feat = next_list[k];
                e.kind = aff_pkg::KIND_APPEND;
                e.fin = 0;
                aligned_slots = {aligned_slots, e};
                n++;
            end
        end
        if (n > 0) aligned_slots[$].fin = 1;
        prev_cnt = 0;
        next_cnt = 0;
    endtask

    // Advance the predictor on each accepted word
    task automatic predict(word_t w);
        aff_pkg::feat_t f;
        f = w.feat;
        case (w.req)
            aff_pkg::REQ_OLD:
            begin
                if (prev_cnt < aff_pkg::MAX_FEAT)
                begin
                    f.angle = aff_pkg::ANGLE_UNDEF;
                    prev_list[prev_cnt++] = f;
                end
            end
            aff_pkg::REQ_NEW:
            begin
                if (next_cnt < aff_pkg::MAX_FEAT) next_list[next_cnt++] = f;
            end
            aff_pkg::REQ_RUN: align_lists();
            default: ;
        endcase
    endtask

    // Monitor: track acceptance and check results
    always @(posedge clk)
    begin
        slot_exp_t e;
        word_t     w;
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("FAIL align_frame_features_core");
            $finish;
        end
        word_taken <= start && !busy;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                w.req = req_type;
                w.feat = '{pos_x, pos_y, feat_size, feat_angle};
                predict(w);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == aff_pkg::CFG_SEARCH) search_lim = cfg_data;
                else if (cfg_index == aff_pkg::CFG_MATCH) match_lim = cfg_data;
            end
            if (result_valid)
            begin
                if (aligned_slots.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d", out_x, out_y);
                    errors++;
                end
                else
                begin
                    e = aligned_slots.pop_front();
                    if (out_x !== e.feat.x)
                    begin
                        $error("out_x exp %0d got %0d", e.feat.x, out_x);
                        errors++;
                    end
                    if (out_y !== e.feat.y)
                    begin
                        $error("out_y exp %0d got %0d", e.feat.y, out_y);
                        errors++;
                    end
                    if (out_size !== e.feat.size)
                    begin
                        $error("out_size exp %0d got %0d", e.feat.size, out_size);
                        errors++;
                    end
                    if (out_angle !== e.feat.angle)
                    begin
                        $error("out_angle exp %0d got %0d", e.feat.angle, out_angle);
                        errors++;
                    end
                    if (slot_kind !== e.kind)
                    begin
                        $error("slot_kind exp %0d got %0d", e.kind, slot_kind);
                        errors++;
                    end
                    if (last !== e.fin)
                    begin
                        $error("last exp %0d got %0d", e.fin, last);
                        errors++;
                    end
                end
            end
        end
    end

    // Driver: hold the word until taken, then advance or idle
    always @(negedge clk)
    begin
        word_t w;
        if (rst_n && (!start || word_taken))
        begin
            if (pending_words.size() == 0 || (!steady && $urandom_range(99) < 14))
                start <= 1'b0;
            else
            begin
                w = pending_words.pop_front();
                start <= 1'b1;
                req_type <= w.req;
                pos_x <= w.feat.x;
                pos_y <= w.feat.y;
                feat_size <= w.feat.size;
                feat_angle <= w.feat.angle;
            end
        end
    end

    // Queue one word; fields wrap to their port widths
    task automatic add_word(logic [1:0] req, int x, int y, int sz, int ang);
        word_t w;
        w.req = req;
        w.feat.x = aff_pkg::CRD_W'(x);
        w.feat.y = aff_pkg::CRD_W'(y);
        w.feat.size = aff_pkg::CRD_W'(sz);
        w.feat.angle = aff_pkg::ANG_W'(ang);
        pending_words = {pending_words, w};
    endtask

    // Wait until all words are taken, results drained and the block is quiet
    task automatic settle();
        do @(negedge clk);
        while (pending_words.size() != 0 || start || aligned_slots.size() != 0 || busy);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(logic [aff_pkg::CFG_IDX_W-1:0] idx,
                             logic [aff_pkg::LIM_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // One random frame: old list, new list mostly near old entries, then run
    task automatic add_frame(int max_len);
        int ox[18];
        int oy[18];
        int n_old;
        int n_new;
        int k;
        n_old = ($urandom_range(7) == 0) ? $urandom_range(18, 15) : $urandom_range(max_len);
        n_new = ($urandom_range(7) == 0) ? $urandom_range(18, 15) : $urandom_range(max_len);
        for (int i = 0; i < n_old; i++)
        begin
            ox[i] = $urandom_range(65535);
            oy[i] = $urandom_range(65535);
            add_word(aff_pkg::REQ_OLD, ox[i], oy[i],
                     ($urandom_range(3) == 0) ? 0 : $urandom, $urandom);
            if ($urandom_range(19) == 0)
                add_word(REQ_SPARE, $urandom, $urandom, $urandom, $urandom);
        end
        for (int i = 0; i < n_new; i++)
        begin
            if (n_old > 0 && $urandom_range(9) < 7)
            begin
                k = $urandom_range(n_old - 1);
                add_word(aff_pkg::REQ_NEW, ox[k] + $urandom_range(40) - 20,
                         oy[k] + $urandom_range(40) - 20,
                         ($urandom_range(9) == 0) ? 0 : $urandom, $urandom);
            end
            else
                add_word(aff_pkg::REQ_NEW, $urandom, $urandom, $urandom, $urandom);
        end
        add_word(aff_pkg::REQ_RUN, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = aff_pkg::REQ_OLD;
        pos_x = '0;
        pos_y = '0;
        feat_size = '0;
        feat_angle = '0;
        cfg_valid = 1'b0;
        cfg_index = aff_pkg::CFG_SEARCH;
        cfg_data = '0;
        steady = 1'b0;
        errors = 0;
        cycles = 0;
        prev_cnt = 0;
        next_cnt = 0;
        search_lim = aff_pkg::SEARCH_RESET;
        match_lim = aff_pkg::MATCH_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, placeholders, empty run, unused request
        add_word(aff_pkg::REQ_RUN, 0, 0, 0, 0);
        add_word(REQ_SPARE, 65535, 65535, 65535, -1);
        add_word(aff_pkg::REQ_OLD, 0, 0, 65535, 5760);
        add_word(aff_pkg::REQ_OLD, 65535, 65535, 0, 0);
        add_word(aff_pkg::REQ_OLD, 100, 100, 0, 0);
        add_word(aff_pkg::REQ_OLD, 5000, 5000, 16, 0);
        add_word(aff_pkg::REQ_NEW, 1, 2, 32, 5760);
        add_word(aff_pkg::REQ_NEW, 65535, 65520, 0, -16);
        add_word(aff_pkg::REQ_NEW, 3000, 3000, 48, 8192);
        add_word(aff_pkg::REQ_NEW, 5001, 5001, 65535, 8191);
        add_word(aff_pkg::REQ_NEW, 40000, 9, 8, 5);
        add_word(aff_pkg::REQ_RUN, 0, 0, 0, 0);
        add_word(aff_pkg::REQ_NEW, 7, 7, 7, 7);
        add_word(aff_pkg::REQ_RUN, 0, 0, 0, 0);
        settle();

        // Match limit above search limit, then both at the extremes
        write_reg(aff_pkg::CFG_SEARCH, 34'd100);
        write_reg(aff_pkg::CFG_MATCH, {aff_pkg::LIM_W{1'b1}});
        add_word(aff_pkg::REQ_OLD, 50, 50, 16, 0);
        add_word(aff_pkg::REQ_NEW, 50, 70, 16, 3);
        add_word(aff_pkg::REQ_NEW, 51, 50, 20, 4);
        add_word(aff_pkg::REQ_RUN, 0, 0, 0, 0);
        settle();
        write_reg(aff_pkg::CFG_SEARCH, {aff_pkg::LIM_W{1'b1}});
        add_frame(6);
        settle();
        write_reg(aff_pkg::CFG_SEARCH, '0);
        write_reg(aff_pkg::CFG_MATCH, '0);
        add_frame(6);
        settle();
        write_reg(aff_pkg::CFG_SEARCH, aff_pkg::SEARCH_RESET);
        write_reg(aff_pkg::CFG_MATCH, aff_pkg::MATCH_RESET);

        // Random frames, one phase with no idling, limits changed in the last two phases
        for (int ph = 0; ph < 5; ph++)
        begin
            steady = (ph == 2);
            if (ph >= 3)
            begin
                write_reg(aff_pkg::CFG_SEARCH,
                          aff_pkg::LIM_W'({$urandom_range(3), $urandom}));
                write_reg(aff_pkg::CFG_MATCH, aff_pkg::LIM_W'($urandom_range(20000)));
            end
            while (pending_words.size() < 30) add_frame(6);
            settle();
        end
        steady = 1'b0;
        if (errors == 0)
            $display("PASS align_frame_features_core");
        else
            $display("FAIL align_frame_features_core");
        $finish;
    end

endmodule
